// ===== rtl/core/sgv_pkg.sv =====
// Shared types, constants and tables for the sensor gain and reference update block.
package sgv_pkg;

    // Widths of the shared divider.
    localparam int unsigned DVD_W = 12;
    localparam int unsigned DSR_W = 8;
    localparam int unsigned STEP_W = $clog2(DVD_W);

    // Sensor index and reference codes.
    localparam int unsigned IDX_W = 7;
    localparam int unsigned ZONE_W = 3;
    localparam logic [IDX_W-1:0] INDEX_MIN = 7'h0c;
    localparam logic [IDX_W-1:0] INDEX_MAX = 7'h7f;
    localparam logic [IDX_W-1:0] REF_RESET = 7'h0c;
    localparam logic [ZONE_W-1:0] ZONE_RESET = 3'd0;

    // Dark level handling.
    localparam logic [15:0] DARK_LIMIT = 16'h0fff;
    localparam logic [DVD_W-1:0] GAIN_DIVIDEND = 12'd128;

    // Sensor register addresses and fixed data.
    localparam logic [15:0] GAIN_HI_ADDR = 16'h00bc;
    localparam logic [15:0] GAIN_LO_ADDR = 16'h00bd;
    localparam logic [15:0] INDEX_ADDR = 16'h00b1;
    localparam logic [15:0] COMMIT_ADDR = 16'h001d;
    localparam logic [7:0] COMMIT_DATA = 8'h02;

    // Mode register set, written in this order.
    localparam int unsigned MODE_COUNT = 8;
    localparam logic [15:0] MODE_ADDR [MODE_COUNT] = '{
        16'h002b, 16'h0030, 16'h0034, 16'h004d, 16'h004f, 16'h0061, 16'h0067, 16'h0068
    };
    localparam logic [7:0] MODE_MATCH [MODE_COUNT] = '{
        8'h10, 8'h01, 8'h01, 8'h03, 8'h0c, 8'h02, 8'h00, 8'h80
    };
    localparam logic [7:0] MODE_OTHER [MODE_COUNT] = '{
        8'h30, 8'h00, 8'h00, 8'h00, 8'h09, 8'h04, 8'h01, 8'h90
    };

    // Dark zone hysteresis table, scanned in order, first hit wins.
    typedef struct packed {
        logic [ZONE_W-1:0] zone;
        logic [DVD_W-1:0]  lo;
        logic [DVD_W-1:0]  hi;
        logic [IDX_W-1:0]  ref_idx;
    } zone_entry_t;

    localparam int unsigned ZONE_COUNT = 5;
    localparam zone_entry_t ZONE_TAB [ZONE_COUNT] = '{
        '{zone: 3'd5, lo: 12'd263, hi: 12'd267, ref_idx: 7'h22},
        '{zone: 3'd4, lo: 12'd216, hi: 12'd220, ref_idx: 7'h1c},
        '{zone: 3'd3, lo: 12'd176, hi: 12'd180, ref_idx: 7'h17},
        '{zone: 3'd2, lo: 12'd130, hi: 12'd134, ref_idx: 7'h12},
        '{zone: 3'd1, lo: 12'd113, hi: 12'd117, ref_idx: 7'h10}
    };
    localparam logic [DVD_W-1:0] ZONE_FLOOR = ZONE_TAB[ZONE_COUNT-1].lo;

    // Request to and result from the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== rtl/core/sgv_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module sgv_divider (
    input  logic              aclk,
    input  logic              aresetn,
    input  sgv_pkg::div_req_t req,
    output sgv_pkg::div_rsp_t rsp
);
    import sgv_pkg::*;

    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [DSR_W:0]    shifted;
    logic              fits;

    // Trial subtraction of the divisor from the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[DVD_W-1]};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = STEP_W'(DVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DSR_W'(shifted - {1'b0, dsr_reg}) : shifted[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    // A new division is never requested while one is running.
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !req.start)
        else $error("divider started while busy");

    // The done pulse never overlaps a running division.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");

    // Every finished division raises done.
    a_fell_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(busy_reg) && !$past(req.start) |-> done_reg)
        else $error("divider finished without done");

endmodule

// ===== rtl/core/sgv_zone.sv =====
// Dark zone tracker with a five-entry hysteresis table.
module sgv_zone (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          update,
    input  logic [sgv_pkg::DVD_W-1:0]     level,
    output logic [sgv_pkg::IDX_W-1:0]     reference_index
);
    import sgv_pkg::*;

    logic [ZONE_W-1:0] dark_zone_reg, dark_zone_next;
    logic [IDX_W-1:0]  reference_index_reg, reference_index_next;
    logic              hit;

    // Low levels drop to zone zero; otherwise the first qualifying entry is taken.
    always_comb begin
        dark_zone_next       = dark_zone_reg;
        reference_index_next = reference_index_reg;
        hit                  = 1'b0;
        if (update) begin
            if (level < ZONE_FLOOR) begin
                dark_zone_next       = ZONE_RESET;
                reference_index_next = REF_RESET;
            end else begin
                for (int i = 0; i < ZONE_COUNT; i++) begin
                    if (!hit &&
                        ((dark_zone_reg < ZONE_TAB[i].zone && level > ZONE_TAB[i].hi) ||
                         (dark_zone_reg > ZONE_TAB[i].zone && level < ZONE_TAB[i].lo))) begin
                        hit                  = 1'b1;
                        dark_zone_next       = ZONE_TAB[i].zone;
                        reference_index_next = ZONE_TAB[i].ref_idx;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dark_zone_reg       <= ZONE_RESET;
            reference_index_reg <= REF_RESET;
        end else begin
            dark_zone_reg       <= dark_zone_next;
            reference_index_reg <= reference_index_next;
        end
    end

    assign reference_index = reference_index_reg;

    // Zone zero always pairs with the base reference.
    a_zone0_ref: assert property (@(posedge aclk) disable iff (!aresetn)
        dark_zone_reg == ZONE_RESET |-> reference_index_reg == REF_RESET)
        else $error("zone zero with wrong reference");

    // The zone never leaves the table's range.
    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dark_zone_reg <= ZONE_TAB[0].zone)
        else $error("dark zone out of range");

    // Without an update the zone holds.
    a_zone_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !update |=> $stable(dark_zone_reg))
        else $error("dark zone changed without update");

endmodule

// ===== rtl/core/sensor_gain_vref_update.sv =====
// Top level: update sequencer, shared divider, zone tracker and write output register.
//
//  channel | direction | handshake          | beat contents
//  s_      | in        | s_valid / s_ready  | exposure, gain index, digital gain, dark level
//  m_      | out       | m_valid / m_ready  | write_addr, write_data, last_write
//  cfg_    | in        | cfg_valid/cfg_ready| exposure register address (16 bits)
//
// An item first runs the shared divider twice (divisor 128/(previous index+1), then the
// scaled dark level), then emits its writes one per cycle into the output register while
// m_ready allows.
// Reset is synchronous: zone 0, reference 0x0c, previous index 0, address 0.
// A low m_ready holds the write sequence; the next item is taken as soon as the last
// write of the current one sits in the output register.
module sensor_gain_vref_update (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_exposure_valid,
    input  logic [15:0] s_exposure_lines,
    input  logic        s_gain_valid,
    input  logic [7:0]  s_analog_gain_index,
    input  logic [11:0] s_digital_gain,
    input  logic [15:0] s_dark_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_write_addr,
    output logic [7:0]  m_write_data,
    output logic        m_last_write
);
    import sgv_pkg::*;

    // Write slots in output order.
    localparam logic [3:0] SLOT_EXP_HI = 4'd0;
    localparam logic [3:0] SLOT_EXP_LO = 4'd1;
    localparam logic [3:0] SLOT_MODE_FIRST = 4'd2;
    localparam logic [3:0] SLOT_GAIN_HI = 4'd10;
    localparam logic [3:0] SLOT_GAIN_LO = 4'd11;
    localparam logic [3:0] SLOT_INDEX = 4'd12;
    localparam logic [3:0] SLOT_COMMIT = 4'd13;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_GAIN,
        ST_DIV_DARK,
        ST_EMIT
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        exp_addr_reg, exp_addr_next;
    logic               exp_valid_reg, exp_valid_next;
    logic [15:0]        exp_lines_reg, exp_lines_next;
    logic               gain_valid_reg, gain_valid_next;
    logic [11:0]        dgain_reg, dgain_next;
    logic [IDX_W-1:0]   index_reg, index_next;
    logic [IDX_W-1:0]   prev_index_reg, prev_index_next;
    logic [DVD_W-1:0]   dark_reg, dark_next;
    logic [3:0]         slot_reg, slot_next;
    logic               m_valid_reg, m_valid_next;
    logic [15:0]        m_addr_reg, m_addr_next;
    logic [7:0]         m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;

    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               zone_update;
    logic [IDX_W-1:0]   reference_index;
    logic               accept;
    logic               out_load;
    logic [IDX_W-1:0]   index_raw;
    logic [2:0]         mode_sel;
    logic               ref_match;
    logic [15:0]        slot_addr;
    logic [7:0]         slot_data;
    logic [3:0]         slot_after;
    logic [3:0]         slot_first;

    sgv_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    sgv_zone u_zone (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .update          (zone_update),
        .level           (div_rsp.quotient),
        .reference_index (reference_index)
    );

    assign accept      = s_valid && s_ready;
    assign out_load    = !m_valid_reg || m_ready;
    assign zone_update = (state_reg == ST_DIV_DARK) && div_rsp.done;

    // Analog index: 127 minus the gain step, or 127 for steps from 128 up, then clamped from below.
    always_comb begin
        index_raw = s_analog_gain_index[7] ? INDEX_MAX
                                           : INDEX_MAX - s_analog_gain_index[IDX_W-1:0];
        if (index_raw < INDEX_MIN) begin
            index_raw = INDEX_MIN;
        end
    end

    // Divider requests: first the divisor from the previous index, then the dark level.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = GAIN_DIVIDEND;
        div_req.divisor  = {1'b0, prev_index_reg} + DSR_W'(1);
        if (accept) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_DIV_GAIN && div_rsp.done) begin
            div_req.start    = 1'b1;
            div_req.dividend = dark_reg;
            div_req.divisor  = div_rsp.quotient[DSR_W-1:0];
        end
    end

    // Address and data of the current write slot.
    assign mode_sel  = 3'(slot_reg - SLOT_MODE_FIRST);
    assign ref_match = index_reg == reference_index;

    always_comb begin
        case (slot_reg)
            SLOT_EXP_HI: begin
                slot_addr = exp_addr_reg;
                slot_data = exp_lines_reg[15:8];
            end
            SLOT_EXP_LO: begin
                slot_addr = exp_addr_reg + 16'd1;
                slot_data = exp_lines_reg[7:0];
            end
            SLOT_GAIN_HI: begin
                slot_addr = GAIN_HI_ADDR;
                slot_data = {4'b0000, dgain_reg[11:8]};
            end
            SLOT_GAIN_LO: begin
                slot_addr = GAIN_LO_ADDR;
                slot_data = dgain_reg[7:0];
            end
            SLOT_INDEX: begin
                slot_addr = INDEX_ADDR;
                slot_data = {1'b0, index_reg};
            end
            SLOT_COMMIT: begin
                slot_addr = COMMIT_ADDR;
                slot_data = COMMIT_DATA;
            end
            default: begin
                slot_addr = MODE_ADDR[mode_sel];
                slot_data = ref_match ? MODE_MATCH[mode_sel] : MODE_OTHER[mode_sel];
            end
        endcase
    end

    // Slot sequencing skips the groups that this item does not write.
    always_comb begin
        slot_first = exp_valid_reg ? SLOT_EXP_HI
                                   : (gain_valid_reg ? SLOT_MODE_FIRST : SLOT_COMMIT);
        case (slot_reg)
            SLOT_EXP_LO: slot_after = gain_valid_reg ? SLOT_MODE_FIRST : SLOT_COMMIT;
            default:     slot_after = slot_reg + 4'd1;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next      = state_reg;
        exp_addr_next   = exp_addr_reg;
        exp_valid_next  = exp_valid_reg;
        exp_lines_next  = exp_lines_reg;
        gain_valid_next = gain_valid_reg;
        dgain_next      = dgain_reg;
        index_next      = index_reg;
        prev_index_next = prev_index_reg;
        dark_next       = dark_reg;
        slot_next       = slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_addr_next     = m_addr_reg;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;

        if (cfg_valid && cfg_ready) begin
            exp_addr_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    exp_valid_next  = s_exposure_valid;
                    exp_lines_next  = s_exposure_lines;
                    gain_valid_next = s_gain_valid;
                    dgain_next      = s_digital_gain;
                    index_next      = index_raw;
                    dark_next       = (s_dark_level > DARK_LIMIT) ? '0
                                                                 : s_dark_level[DVD_W-1:0];
                    if (s_gain_valid) begin
                        prev_index_next = index_raw;
                    end
                    state_next = ST_DIV_GAIN;
                end
            end
            ST_DIV_GAIN: begin
                if (div_rsp.done) begin
                    state_next = ST_DIV_DARK;
                end
            end
            ST_DIV_DARK: begin
                if (div_rsp.done) begin
                    slot_next  = slot_first;
                    state_next = (exp_valid_reg || gain_valid_reg) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = slot_addr;
                    m_data_next  = slot_data;
                    m_last_next  = slot_reg == SLOT_COMMIT;
                    slot_next    = slot_after;
                    if (slot_reg == SLOT_COMMIT) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            exp_addr_reg   <= '0;
            prev_index_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            exp_addr_reg   <= exp_addr_next;
            prev_index_reg <= prev_index_next;
            m_valid_reg    <= m_valid_next;
        end
        exp_valid_reg  <= exp_valid_next;
        exp_lines_reg  <= exp_lines_next;
        gain_valid_reg <= gain_valid_next;
        dgain_reg      <= dgain_next;
        index_reg      <= index_next;
        dark_reg       <= dark_next;
        slot_reg       <= slot_next;
        m_addr_reg     <= m_addr_next;
        m_data_reg     <= m_data_next;
        m_last_reg     <= m_last_next;
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_write_addr = m_addr_reg;
    assign m_write_data = m_data_reg;
    assign m_last_write = m_last_reg;

    // An accepted item keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input accepted twice in a row");

    // Writes are only produced while the sequencer is emitting.
    a_load_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_EMIT && !m_valid_reg |=> !m_valid_reg)
        else $error("write produced outside the emit phase");

    // The closing write of an item is always the commit.
    a_last_is_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_addr_reg == COMMIT_ADDR)
        else $error("last write is not the commit");

endmodule
